// File: hw/rtl/gda_pkg.sv
package gda_pkg;

    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_SUB  = 2'd1;
    localparam logic [1:0] CMD_DIFF = 2'd2;

    localparam logic [13:0] LAST_YEAR   = 14'd9999;
    localparam logic [3:0]  LAST_MONTH  = 4'd12;
    localparam logic [21:0] LAST_DAYNUM = 22'd3652058;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_t;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] n;
        case (m) inside
            4'd2:                      n = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

    // days before the first of month m in a common year
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

// File: hw/rtl/gregorian_date_arithmetic_unit.sv
// channel    handshake              payload
// request    req_valid/req_ready    command year month day day_count other_*
// response   rsp_valid/rsp_ready    out_year out_month out_day day_difference flags
//
// Twelve-stage pipeline, one request per cycle while req_ready is high.
// Depth comes from the date/day-number conversions, at most one
// constant multiply on any stage path.
// Reset clears only the stage valid bits.
// Each stage holds while the one after it is full and not moving, so a
// stalled response leaves room for requests in the empty stages upstream.
module gregorian_date_arithmetic_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  command,
    input  logic [13:0] year,
    input  logic [3:0]  month,
    input  logic [4:0]  day,
    input  logic [21:0] day_count,
    input  logic [13:0] other_year,
    input  logic [3:0]  other_month,
    input  logic [4:0]  other_day,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [13:0] out_year,
    output logic [3:0]  out_month,
    output logic [4:0]  out_day,
    output logic [21:0] day_difference,
    output logic        first_earlier,
    output logic        dates_equal,
    output logic        range_error
);

    localparam int NSTAGE = 12;

    typedef struct packed {
        logic [21:0] diff;
        logic        lt;
        logic        eq;
        logic        err;
        logic        date_en;
    } side_t;

    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] free;

    logic [1:0]     cmd_reg [4];
    logic [21:0]    cnt_reg [4];
    gda_pkg::date_t da_reg;
    gda_pkg::date_t db_reg;

    logic [21:0]    num_a;
    logic [21:0]    num_b;

    logic [22:0]    sum;
    logic [21:0]    r_next;
    side_t          side_next;
    logic [21:0]    r_reg;
    side_t          side_reg [4:10];

    gda_pkg::date_t res_date;

    logic [13:0]    out_year_reg;
    logic [3:0]     out_month_reg;
    logic [4:0]     out_day_reg;
    logic [21:0]    diff_reg;
    logic           lt_reg;
    logic           eq_reg;
    logic           err_reg;

    always_comb
    begin
        free[NSTAGE-1] = !v_reg[NSTAGE-1] || rsp_ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
            free[i] = !v_reg[i] || free[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (free[0])
                v_reg[0] <= req_valid;
            for (int i = 1; i < NSTAGE; i++)
            begin
                if (free[i])
                    v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (free[0])
        begin
            cmd_reg[0]   <= command;
            cnt_reg[0]   <= day_count;
            da_reg.year  <= year;
            da_reg.month <= month;
            da_reg.day   <= day;
            db_reg.year  <= other_year;
            db_reg.month <= other_month;
            db_reg.day   <= other_day;
        end
        for (int i = 1; i < 4; i++)
        begin
            if (free[i])
            begin
                cmd_reg[i] <= cmd_reg[i-1];
                cnt_reg[i] <= cnt_reg[i-1];
            end
        end
    end

    gda_date2num u_d2n_a (
        .clk    (clk),
        .load   (free[3:1]),
        .date   (da_reg),
        .daynum (num_a)
    );

    gda_date2num u_d2n_b (
        .clk    (clk),
        .load   (free[3:1]),
        .date   (db_reg),
        .daynum (num_b)
    );

    always_comb
    begin
        sum               = {1'b0, num_a} + {1'b0, cnt_reg[3]};
        r_next            = '0;
        side_next.diff    = '0;
        side_next.lt      = (num_a < num_b);
        side_next.eq      = (num_a == num_b);
        side_next.err     = 1'b0;
        side_next.date_en = 1'b0;
        unique case (cmd_reg[3])
            gda_pkg::CMD_ADD:
            begin
                side_next.date_en = 1'b1;
                if (sum > {1'b0, gda_pkg::LAST_DAYNUM})
                begin
                    side_next.err = 1'b1;
                    r_next        = gda_pkg::LAST_DAYNUM;
                end
                else
                    r_next = sum[21:0];
            end
            gda_pkg::CMD_SUB:
            begin
                side_next.date_en = 1'b1;
                if (cnt_reg[3] > num_a)
                    side_next.err = 1'b1;
                else
                    r_next = num_a - cnt_reg[3];
            end
            gda_pkg::CMD_DIFF:
                side_next.diff = (num_a > num_b) ? (num_a - num_b) : (num_b - num_a);
            default:
                side_next.diff = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (free[4])
        begin
            r_reg       <= r_next;
            side_reg[4] <= side_next;
        end
        for (int i = 5; i <= 10; i++)
        begin
            if (free[i])
                side_reg[i] <= side_reg[i-1];
        end
    end

    gda_num2date u_n2d (
        .clk    (clk),
        .load   (free[10:5]),
        .daynum (r_reg),
        .date   (res_date)
    );

    always_ff @(posedge clk)
    begin
        if (free[11])
        begin
            out_year_reg  <= side_reg[10].date_en ? res_date.year  : 14'd0;
            out_month_reg <= side_reg[10].date_en ? res_date.month : 4'd0;
            out_day_reg   <= side_reg[10].date_en ? res_date.day   : 5'd0;
            diff_reg      <= side_reg[10].diff;
            lt_reg        <= side_reg[10].lt;
            eq_reg        <= side_reg[10].eq;
            err_reg       <= side_reg[10].err;
        end
    end

    assign req_ready      = free[0];
    assign rsp_valid      = v_reg[NSTAGE-1];
    assign out_year       = out_year_reg;
    assign out_month      = out_month_reg;
    assign out_day        = out_day_reg;
    assign day_difference = diff_reg;
    assign first_earlier  = lt_reg;
    assign dates_equal    = eq_reg;
    assign range_error    = err_reg;

endmodule

// File: hw/rtl/gda_date2num.sv
module gda_date2num (
    input  logic                clk,
    input  logic [2:0]          load,
    input  gda_pkg::date_t      date,
    output logic [21:0]         daynum
);

    logic [13:0] yc;
    logic [3:0]  mc;
    logic [13:0] y1;
    logic [26:0] prod;

    logic [13:0] y1_reg;
    logic [7:0]  q1_reg;
    logic [3:0]  m_reg;
    logic [4:0]  d_reg;

    logic [13:0] rem100;
    logic        cent;
    logic        leap;
    logic        feb_adj;
    logic [4:0]  mlen;
    logic [4:0]  dc;
    logic [8:0]  yday;
    logic [21:0] ybase;

    logic [8:0]  yday_reg;
    logic [21:0] ybase_reg;
    logic [21:0] daynum_reg;

    // clamp, (year-1)/100 by reciprocal
    always_comb
    begin
        if (date.year == 14'd0)
            yc = 14'd1;
        else if (date.year > gda_pkg::LAST_YEAR)
            yc = gda_pkg::LAST_YEAR;
        else
            yc = date.year;
        if (date.month == 4'd0)
            mc = 4'd1;
        else if (date.month > gda_pkg::LAST_MONTH)
            mc = gda_pkg::LAST_MONTH;
        else
            mc = date.month;
        y1   = yc - 14'd1;
        prod = 27'(y1) * 27'd5243;
    end

    always_comb
    begin
        rem100  = y1_reg - 14'(15'(q1_reg) * 15'd100);
        cent    = (rem100 == 14'd99);
        leap    = ((y1_reg[1:0] == 2'b11) && !cent) || (cent && (q1_reg[1:0] == 2'b11));
        feb_adj = leap && (m_reg > 4'd2);
        mlen    = gda_pkg::month_len(m_reg) + {4'd0, (m_reg == 4'd2) && leap};
        if (d_reg == 5'd0)
            dc = 5'd1;
        else if (d_reg > mlen)
            dc = mlen;
        else
            dc = d_reg;
        yday  = gda_pkg::cum_days(m_reg) + {8'd0, feb_adj} + {4'd0, dc} - 9'd1;
        ybase = 22'(y1_reg) * 22'd365 + {10'd0, y1_reg[13:2]}
                - {14'd0, q1_reg} + {16'd0, q1_reg[7:2]};
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            y1_reg <= y1;
            q1_reg <= prod[26:19];
            m_reg  <= mc;
            d_reg  <= date.day;
        end
        if (load[1])
        begin
            yday_reg  <= yday;
            ybase_reg <= ybase;
        end
        if (load[2])
            daynum_reg <= ybase_reg + {13'd0, yday_reg};
    end

    assign daynum = daynum_reg;

endmodule

// File: hw/rtl/gda_num2date.sv
module gda_num2date (
    input  logic                clk,
    input  logic [5:0]          load,
    input  logic [21:0]         daynum,
    output gda_pkg::date_t      date
);

    logic [44:0] p400;
    logic [21:0] n_reg;
    logic [4:0]  c400_reg;

    logic [21:0] r400;
    logic [17:0] r_reg;
    logic [4:0]  c400b_reg;

    logic [1:0]  c100;
    logic [15:0] r2;
    logic [15:0] r2_reg;
    logic [1:0]  c100_reg;
    logic [4:0]  c400c_reg;

    logic [31:0] p4;
    logic [15:0] r2b_reg;
    logic [4:0]  c4_reg;
    logic [1:0]  c100b_reg;
    logic [4:0]  c400d_reg;

    logic [15:0] r3w;
    logic [13:0] ypart;
    logic [10:0] r3_reg;
    logic [13:0] ypart_reg;
    logic [4:0]  c4b_reg;
    logic [1:0]  c100c_reg;

    logic [1:0]  c1;
    logic [10:0] r4w;
    logic [8:0]  r4_reg;
    logic [13:0] y_reg;
    logic        leap_reg;

    logic [3:0]  mo;
    logic [8:0]  before_mo;

    always_comb
    begin
        p400 = 45'(daynum) * 45'd7525902;
        r400 = n_reg - 22'(23'(c400_reg) * 23'd146097);
        c100 = 2'({1'b0, r_reg >= 18'd36524} + {1'b0, r_reg >= 18'd73048}
                  + {1'b0, r_reg >= 18'd109572});
        r2   = 16'(r_reg - 18'(20'(c100) * 20'd36524));
        p4   = 32'(r2_reg) * 32'd91868;
        r3w  = r2b_reg - 16'(16'(c4_reg) * 16'd1461);
        ypart = 14'(c400d_reg) * 14'd400 + 14'(c100b_reg) * 14'd100
                + {7'd0, c4_reg, 2'b00} + 14'd1;
        c1   = 2'({1'b0, r3_reg >= 11'd365} + {1'b0, r3_reg >= 11'd730}
                  + {1'b0, r3_reg >= 11'd1095});
        r4w  = r3_reg - 11'(11'(c1) * 11'd365);
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            n_reg    <= daynum;
            c400_reg <= p400[44:40];
        end
        if (load[1])
        begin
            r_reg     <= r400[17:0];
            c400b_reg <= c400_reg;
        end
        if (load[2])
        begin
            r2_reg    <= r2;
            c100_reg  <= c100;
            c400c_reg <= c400b_reg;
        end
        if (load[3])
        begin
            r2b_reg   <= r2_reg;
            c4_reg    <= p4[31:27];
            c100b_reg <= c100_reg;
            c400d_reg <= c400c_reg;
        end
        if (load[4])
        begin
            r3_reg    <= r3w[10:0];
            ypart_reg <= ypart;
            c4b_reg   <= c4_reg;
            c100c_reg <= c100b_reg;
        end
        if (load[5])
        begin
            r4_reg   <= r4w[8:0];
            y_reg    <= ypart_reg + {12'd0, c1};
            leap_reg <= (c1 == 2'd3) && ((c4b_reg != 5'd24) || (c100c_reg == 2'd3));
        end
    end

    always_comb
    begin
        mo = 4'd1;
        for (int k = 2; k <= 12; k++)
        begin
            if (r4_reg >= gda_pkg::cum_days(4'(k)) + {8'd0, leap_reg && (k > 2)})
                mo = 4'(k);
        end
        before_mo  = gda_pkg::cum_days(mo) + {8'd0, leap_reg && (mo > 4'd2)};
        date.year  = y_reg;
        date.month = mo;
        date.day   = 5'(r4_reg - before_mo + 9'd1);
    end

endmodule

// File: hw/rtl/gda_checker.sv
module gda_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [13:0] out_year,
    input logic [3:0]  out_month,
    input logic [4:0]  out_day,
    input logic [21:0] day_difference,
    input logic        first_earlier,
    input logic        dates_equal,
    input logic        range_error
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
        && $stable({out_year, out_month, out_day, day_difference,
                    first_earlier, dates_equal, range_error}))
        else $error("stalled response changed");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(first_earlier && dates_equal))
        else $error("earlier and equal both set");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && range_error |->
        (out_year == 14'd9999 && out_month == 4'd12 && out_day == 5'd31)
        || (out_year == 14'd1 && out_month == 4'd1 && out_day == 5'd1))
        else $error("range error without limit date");

    a_diff_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && day_difference != 22'd0 |->
        out_year == 14'd0 && !range_error && !dates_equal)
        else $error("difference with date result");

    a_date_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && out_year != 14'd0 |->
        out_month >= 4'd1 && out_month <= 4'd12 && out_day >= 5'd1 && out_day <= 5'd31)
        else $error("bad result date");

endmodule

bind gregorian_date_arithmetic_unit gda_checker u_gda_checker (.*);
